@@ rtl/hfdr_pkg.sv @@
// Package for the histogram FDR voxel scorer: widths, operation codes,
// register indexes and shared types. No dependencies.
`default_nettype none
package hfdr_pkg;
  localparam int MAX_BINS_DEF   = 256;
  localparam int COUNT_BITS_DEF = 32;
  localparam logic [16:0] ONE_Q16     = 17'd65536;
  localparam logic [16:0] ALPHA_LIMIT = 17'd64881;

  localparam logic [1:0] OP_LOAD_NULL = 2'd0;
  localparam logic [1:0] OP_LOAD_REAL = 2'd1;
  localparam logic [1:0] OP_BUILD     = 2'd2;
  localparam logic [1:0] OP_SCORE     = 2'd3;

  localparam logic [2:0] REG_ALPHA      = 3'd0;
  localparam logic [2:0] REG_RANGE_LOW  = 3'd1;
  localparam logic [2:0] REG_RANGE_HIGH = 3'd2;
  localparam logic [2:0] REG_BIN_SCALE  = 3'd3;
  localparam logic [2:0] REG_BINS_USED  = 3'd4;

  typedef struct packed {
    logic       kind;
    logic [16:0] sig;
    logic       err;
  } hfdr_res_t;
endpackage
`default_nettype wire

@@ rtl/hfdr_ram.sv @@
// Generic single-port-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module hfdr_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

@@ rtl/hfdr_div.sv @@
// Restoring divider: num/den to a Q1.16 quotient, one quotient bit a cycle,
// saturating at one. Depends on hfdr_pkg.
`default_nettype none
module hfdr_div #(
  parameter int W = 64
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         go,
  input  wire logic [W-1:0] num,
  input  wire logic [W-1:0] den,
  output      logic         done,
  output      logic [16:0]  quo
);
  import hfdr_pkg::*;
  logic [W:0]   rem_r, rem_nxt;
  logic [W-1:0] den_r;
  logic [16:0]  q_r, q_nxt;
  logic [4:0]   cnt_r, cnt_nxt;
  logic         busy_r, busy_nxt, done_r, done_nxt;
  logic [W+1:0] sh;

  always_comb begin
    rem_nxt = rem_r; q_nxt = q_r; cnt_nxt = cnt_r; busy_nxt = busy_r;
    done_nxt = 1'b0;
    sh = {rem_r, 1'b0};
    if (go) begin
      if (num >= den) begin
        q_nxt = ONE_Q16; done_nxt = 1'b1; busy_nxt = 1'b0;
      end else begin
        rem_nxt = {1'b0, num}; q_nxt = '0; cnt_nxt = '0; busy_nxt = 1'b1;
      end
    end else if (busy_r) begin
      // shift in, subtract when it fits
      if (sh >= {2'b0, den_r}) begin
        rem_nxt = (W+1)'(sh - {2'b0, den_r});
        q_nxt = {q_r[15:0], 1'b1};
      end else begin
        rem_nxt = sh[W:0];
        q_nxt = {q_r[15:0], 1'b0};
      end
      cnt_nxt = cnt_r + 5'd1;
      if (cnt_r == 5'd15) begin
        busy_nxt = 1'b0; done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0; done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt; done_r <= done_nxt;
    end
    rem_r <= rem_nxt; q_r <= q_nxt; cnt_r <= cnt_nxt;
    if (go) den_r <= den;
  end
  assign done = done_r;
  assign quo  = q_r;
endmodule
`default_nettype wire

@@ rtl/histogram_fdr_voxel_scorer.sv @@
// Top level of the histogram FDR voxel scorer: sequencer, count and table
// memories, APB registers. Depends on hfdr_pkg, hfdr_ram, hfdr_div.
//
// Channel | Direction | Handshake
// in_     | input     | start & !busy accepts a beat
// out_    | output    | out_valid one cycle per result beat, no stall
// cfg_    | APB       | psel & penable & pwrite & pready writes
//
// Load: busy while the count is written. Score: multiply, index clamp,
// table read; stops at once below range or at zero, no clamp at or above
// range_high. Build: sums, then per bin read, four 32x32 partial products,
// divider, write; the divider answers at once when the ratio saturates, and
// a bin goes straight to write once the real sum is used up. A zero-total
// build sweeps all MAX_BINS entries, one per cycle. A result strobes as busy
// drops. Reset is synchronous; the table reads one until a build writes it.
`default_nettype none
module histogram_fdr_voxel_scorer #(
  parameter int MAX_BINS   = hfdr_pkg::MAX_BINS_DEF,
  parameter int COUNT_BITS = hfdr_pkg::COUNT_BITS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output      logic               busy,
  input  wire logic [1:0]         in_operation,
  input  wire logic [7:0]         in_bin_index,
  input  wire logic [31:0]        in_bin_count,
  input  wire logic signed [31:0] in_voxel_value,
  output      logic               out_valid,
  output      logic               out_result_kind,
  output      logic [16:0]        out_significance,
  output      logic               out_table_error,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [4:0]         paddr,
  input  wire logic [31:0]        pwdata,
  output      logic [31:0]        prdata,
  output      logic               pready
);
  import hfdr_pkg::*;
  localparam int AW = $clog2(MAX_BINS);
  localparam int NW = $clog2(MAX_BINS + 1);
  localparam int CW = COUNT_BITS;
  localparam int SW = CW + AW + 1;   // sum width
  localparam int PW = 2 * SW;         // product width

  localparam logic [3:0] S_IDLE = 4'd0, S_SUM = 4'd1, S_CHK = 4'd2,
    S_RD = 4'd3, S_MUL = 4'd4, S_DIV = 4'd5, S_WR = 4'd6, S_FILL = 4'd7,
    S_SC1 = 4'd8, S_SC2 = 4'd9, S_SC3 = 4'd10, S_DONE = 4'd11, S_LD = 4'd12;

  // configuration
  logic [16:0] alpha_r;
  logic signed [31:0] rlo_r, rhi_r;
  logic [31:0] scale_r;
  logic [8:0]  bused_r;
  logic        wr_en;
  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alpha_r <= 17'd3277; rlo_r <= '0; rhi_r <= 32'sd65536;
      scale_r <= 32'd16777216; bused_r <= 9'd256;
    end else if (wr_en) begin
      unique case (paddr[4:2])
        REG_ALPHA:      alpha_r <= pwdata[16:0];
        REG_RANGE_LOW:  rlo_r   <= pwdata;
        REG_RANGE_HIGH: rhi_r   <= pwdata;
        REG_BIN_SCALE:  scale_r <= pwdata;
        REG_BINS_USED:  bused_r <= pwdata[8:0];
        default: ;
      endcase
    end
  end
  always_comb begin
    unique case (paddr[4:2])
      REG_ALPHA:      prdata = {15'd0, alpha_r};
      REG_RANGE_LOW:  prdata = rlo_r;
      REG_RANGE_HIGH: prdata = rhi_r;
      REG_BIN_SCALE:  prdata = scale_r;
      REG_BINS_USED:  prdata = {23'd0, bused_r};
      default:        prdata = '0;
    endcase
  end

  logic [NW-1:0] nact;
  always_comb begin
    if (bused_r == 9'd0) nact = NW'(1);
    else if ({23'd0, bused_r} > 32'(MAX_BINS)) nact = NW'(MAX_BINS);
    else nact = NW'(bused_r);
  end

  logic [3:0]    st_r;
  logic [NW-1:0] i_r;
  logic [1:0]    op_r;
  logic [AW-1:0] bi_r;
  logic [CW-1:0] cnt_r;
  logic signed [31:0] vox_r;
  logic [SW-1:0] t0_r, tz_r, c0_r, cz_r;
  logic [PW-1:0] pn_r, pd_r;
  logic [1:0]    ph_r;
  logic [16:0]   prev_r, f_r;
  logic          bad_r;
  logic [MAX_BINS-1:0] tv_r;   // table entry valid
  hfdr_res_t     res_r;
  logic          ov_r;
  logic [63:0]   prod_r;
  logic [AW-1:0] idx_r;
  logic          dgo_r;

  // clamp to a non-increasing table, force bin 0 to one
  logic [16:0] fv;
  assign fv = (i_r == '0) ? ONE_Q16 : ((f_r > prev_r) ? prev_r : f_r);

  // memories
  logic          nwe, rwe, fwe;
  logic [AW-1:0] raddr, faddr;
  logic [CW-1:0] nq, rq;
  logic [16:0]   fq, fwd;
  assign nwe = (st_r == S_LD) && (op_r == OP_LOAD_NULL);
  assign rwe = (st_r == S_LD) && (op_r == OP_LOAD_REAL);
  assign raddr = i_r[AW-1:0];
  hfdr_ram #(.WIDTH(CW), .DEPTH(MAX_BINS)) u_null (.clk, .we(nwe), .waddr(bi_r),
    .wdata(cnt_r), .raddr(raddr), .rdata(nq));
  hfdr_ram #(.WIDTH(CW), .DEPTH(MAX_BINS)) u_real (.clk, .we(rwe), .waddr(bi_r),
    .wdata(cnt_r), .raddr(raddr), .rdata(rq));
  assign fwe = (st_r == S_WR) || (st_r == S_FILL);
  assign fwd = (st_r == S_FILL) ? ONE_Q16 : fv;
  assign faddr = (st_r == S_SC2) ? idx_r : i_r[AW-1:0];
  hfdr_ram #(.WIDTH(17), .DEPTH(MAX_BINS)) u_fdr (.clk, .we(fwe),
    .waddr(i_r[AW-1:0]), .wdata(fwd), .raddr(faddr), .rdata(fq));

  // 32x32 partial products of the wide multiply, one per cycle
  logic [PW-1:0] ma, mb, da, db;
  logic [63:0]   mpart;
  logic [31:0]   opa, opb;
  logic [PW-1:0] addend;
  assign ma = PW'(t0_r - c0_r);
  assign mb = PW'(tz_r);
  assign da = PW'(t0_r);
  assign db = PW'(tz_r - cz_r);
  always_comb begin
    opa = ph_r[1] ? 32'(ma >> 32) : ma[31:0];
    opb = ph_r[0] ? 32'(mb >> 32) : mb[31:0];
    mpart = 64'(opa) * 64'(opb);
    addend = PW'(mpart) << (32 * (32'(ph_r[1]) + 32'(ph_r[0])));
  end
  logic [31:0]   dpa, dpb;
  logic [63:0]   dpart;
  logic [PW-1:0] dadd;
  always_comb begin
    dpa = ph_r[1] ? 32'(da >> 32) : da[31:0];
    dpb = ph_r[0] ? 32'(db >> 32) : db[31:0];
    dpart = 64'(dpa) * 64'(dpb);
    dadd = PW'(dpart) << (32 * (32'(ph_r[1]) + 32'(ph_r[0])));
  end

  logic        dgo, ddone;
  logic [16:0] dq;
  hfdr_div #(.W(PW)) u_div (.clk, .rst_n, .go(dgo), .num(pn_r), .den(pd_r),
    .done(ddone), .quo(dq));

  logic signed [32:0] vdiff;
  assign vdiff = 33'(vox_r) - 33'(rlo_r);
  logic [31:0] pos;
  assign pos = prod_r[63:32];

  logic accept;
  assign busy   = (st_r != S_IDLE);
  assign accept = start && !busy;
  // start the divider once all four partial products are summed
  assign dgo    = dgo_r;

  logic [16:0] fent, sig;
  assign fent = tv_r[idx_r] ? fq : ONE_Q16;
  always_comb begin
    sig = ONE_Q16 - fent;
    if (alpha_r < ALPHA_LIMIT && sig < (ONE_Q16 - alpha_r)) sig = '0;
  end

  logic last_wr, fill_end, sc_drop, ov_nxt;
  assign last_wr  = (i_r == nact - 1'b1);
  assign fill_end = (i_r == NW'(MAX_BINS - 1));
  assign sc_drop  = !(vox_r >= rhi_r) && (vox_r < rlo_r || vox_r == 32'sd0);
  assign ov_nxt   = ((st_r == S_FILL) && fill_end) || ((st_r == S_WR) && last_wr) ||
                    ((st_r == S_SC1) && sc_drop) ||
                    ((st_r == S_DONE) && (op_r == OP_SCORE));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE; bad_r <= 1'b0; tv_r <= '0; ov_r <= 1'b0; dgo_r <= 1'b0;
    end else begin
      ov_r  <= ov_nxt;
      dgo_r <= (st_r == S_MUL) && (ph_r == 2'd3);
      unique case (st_r)
        S_IDLE: if (accept) begin
          op_r <= in_operation; bi_r <= AW'(in_bin_index);
          cnt_r <= CW'(in_bin_count); vox_r <= in_voxel_value;
          i_r <= '0; t0_r <= '0; tz_r <= '0;
          unique case (in_operation)
            OP_LOAD_NULL, OP_LOAD_REAL:
              st_r <= (32'(in_bin_index) < MAX_BINS) ? S_LD : S_DONE;
            OP_BUILD: st_r <= S_SUM;
            default:  st_r <= S_SC1;
          endcase
        end
        S_LD: st_r <= S_IDLE;
        S_SUM: begin
          // read address i, data lands next cycle; i_r runs one ahead
          if (i_r != '0) begin
            t0_r <= t0_r + SW'(nq); tz_r <= tz_r + SW'(rq);
          end
          if (i_r == nact) begin
            st_r <= S_CHK;
          end else i_r <= i_r + 1'b1;
        end
        S_CHK: begin
          i_r <= '0; c0_r <= '0; cz_r <= '0;
          if (t0_r == '0 || tz_r == '0) begin
            bad_r <= 1'b1; st_r <= S_FILL;
          end else begin
            bad_r <= 1'b0; st_r <= S_RD;
          end
        end
        S_FILL: begin
          tv_r[i_r[AW-1:0]] <= 1'b1;
          if (fill_end) begin
            res_r <= '{kind: 1'b0, sig: '0, err: 1'b1};
            st_r <= S_IDLE;
          end else i_r <= i_r + 1'b1;
        end
        S_RD: begin
          pn_r <= '0; pd_r <= '0; ph_r <= '0;
          if (cz_r < tz_r) st_r <= S_MUL;
          else begin
            f_r <= ONE_Q16; st_r <= S_WR;
          end
        end
        S_MUL: begin
          pn_r <= pn_r + addend; pd_r <= pd_r + dadd;
          ph_r <= ph_r + 2'd1;
          if (ph_r == 2'd3) st_r <= S_DIV;
        end
        S_DIV: if (ddone) begin
          f_r <= dq; st_r <= S_WR;
        end
        S_WR: begin
          // nq/rq still hold bin i
          f_r <= fv;
          prev_r <= fv;
          tv_r[i_r[AW-1:0]] <= 1'b1;
          c0_r <= c0_r + SW'(nq); cz_r <= cz_r + SW'(rq);
          if (last_wr) begin
            res_r <= '{kind: 1'b0, sig: '0, err: 1'b0};
            st_r <= S_IDLE;
          end else begin
            i_r <= i_r + 1'b1; st_r <= S_RD;
          end
        end
        S_SC1: begin
          prod_r <= 64'(vdiff[31:0]) * 64'(scale_r);
          if (vox_r >= rhi_r) begin
            idx_r <= AW'(nact - 1'b1); st_r <= S_SC2;
          end else if (vox_r < rlo_r || vox_r == 32'sd0) begin
            res_r <= '{kind: 1'b1, sig: '0, err: bad_r};
            st_r <= S_IDLE;
          end else st_r <= S_SC3;
        end
        S_SC3: begin
          idx_r <= (pos >= 32'(nact)) ? AW'(nact - 1'b1) : AW'(pos);
          st_r <= S_SC2;
        end
        S_SC2: st_r <= S_DONE;
        S_DONE: begin
          if (op_r == OP_SCORE) begin
            res_r <= '{kind: 1'b1, sig: sig, err: bad_r};
          end
          st_r <= S_IDLE;
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid        = ov_r;
  assign out_result_kind  = res_r.kind;
  assign out_significance = res_r.sig;
  assign out_table_error  = res_r.err;
endmodule
`default_nettype wire

@@ rtl/hfdr_checker.sv @@
// Port-level checker for the histogram FDR voxel scorer, bound to the top.
// Depends on hfdr_pkg.
`default_nettype none
module hfdr_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        start,
  input wire logic        busy,
  input wire logic        out_valid,
  input wire logic        out_result_kind,
  input wire logic [16:0] out_significance,
  input wire logic        pready
);
  import hfdr_pkg::*;
  a_ready: assert property (@(posedge clk) pready) else $error("pready low");
  a_build_sig: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_result_kind |-> out_significance == '0)
    else $error("build beat carries significance");
  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_significance <= ONE_Q16) else $error("significance range");
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy) else $error("not busy after accept");
  a_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("back to back results");
endmodule
bind histogram_fdr_voxel_scorer hfdr_checker u_hfdr_checker (.*);
`default_nettype wire
